/* sv/fca_pkg.sv */
// Shared constants, types and entry address helpers for the FAT12 allocator.
package fca_pkg;

   localparam int MAX_CLUSTERS = 4096;
   localparam int TABLE_BYTES  = 6144;

   localparam int ADDR_W = 13;   // table byte address
   localparam int CL_W   = 12;   // one FAT12 entry / cluster number
   localparam int CN_W   = 13;   // cluster walker, reaches MAX_CLUSTERS
   localparam int DSB_W  = 16;   // data sector base
   localparam int SEC_W  = 17;   // data sector result
   localparam int CSR_W  = 2;    // configuration register index

   localparam logic [CL_W-1:0] EOC_MARK      = 12'hFFF;
   localparam logic [CN_W-1:0] FIRST_CLUSTER = 13'd2;

   typedef enum logic [2:0] {
      ACT_LOAD   = 3'd0,
      ACT_READ   = 3'd1,
      ACT_START  = 3'd2,
      ACT_APPEND = 3'd3,
      ACT_COUNT  = 3'd4
   } action_type;

   localparam logic [CSR_W-1:0] CSR_ALLOC_LIMIT = 2'd0;
   localparam logic [CSR_W-1:0] CSR_COUNT_LIMIT = 2'd1;
   localparam logic [CSR_W-1:0] CSR_DATA_BASE   = 2'd2;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   // First table byte of entry n: floor(3n/2).
   function automatic logic [CN_W:0] byte_of(input logic [CN_W-1:0] n);
      logic [CN_W+1:0] t;
      t = {2'b00, n} + {1'b0, n, 1'b0};
      return t[CN_W+1:1];
   endfunction

   // Entry n is usable only if both of its bytes lie inside the table.
   function automatic logic entry_exists(input logic [CN_W-1:0] n);
      logic [CN_W+1:0] last;
      last = {1'b0, byte_of(n)} + (CN_W+2)'(1);
      return (n < CN_W'(MAX_CLUSTERS)) && (last < (CN_W+2)'(TABLE_BYTES));
   endfunction

endpackage

/* sv/fca_table_ram.sv */
// Byte store holding the packed FAT12 table, one write and one registered read port.
module fca_table_ram
   import fca_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output logic [7:0]  rd_data_ff
);

   logic [7:0] mem [TABLE_BYTES];

   // drop writes beyond the table
   always_ff @(posedge clock) begin
      if (mem_req.wr_en && (mem_req.wr_addr < ADDR_W'(TABLE_BYTES))) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // hold the last data on a read beyond the table
   always_ff @(posedge clock) begin
      if (mem_req.rd_en && (mem_req.rd_addr < ADDR_W'(TABLE_BYTES))) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

endmodule

/* sv/fat12_cluster_chain_allocator.sv */
// Top level of the FAT12 cluster chain allocator: sequencer, scan walker and registers.
//
// Usage: a transaction is accepted on a rising edge with start high and busy low;
// req_action selects load byte, read byte, start chain, append cluster or count free.
// Every accepted transaction yields exactly one result, shown for one cycle with
// rsp_valid high; the receiver cannot stall, so results are never held back.
// Configuration (alloc limit, count limit, data sector base) goes through the csr_
// channel, which is always ready; write it only while the block is idle.
// Load and unknown actions give their result in the cycle after accept; a read
// passes through ST_READ, where the registered table byte enters the result. Start
// chain, append and count stream the table bytes through the single read port, one
// byte a cycle. An allocation then adds a read-modify-write per entry touched: one
// for start, two for an append that links the old tail. For read and the walking
// actions, busy stays high from accept until the result strobe.
// Reset clears the sequencer, the tail cluster, the limits and the data sector base
// to their defaults; the table contents are undefined until loaded byte by byte.
module fat12_cluster_chain_allocator
   import fca_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [2:0]        req_action,
   input  logic [ADDR_W-1:0] req_byte_address,
   input  logic [7:0]        req_byte_value,
   output logic              rsp_valid,
   output logic              rsp_status,
   output logic [CL_W-1:0]   rsp_cluster,
   output logic [SEC_W-1:0]  rsp_data_sector,
   output logic [CL_W-1:0]   rsp_free_clusters,
   output logic [7:0]        rsp_read_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_W-1:0]  csr_index,
   input  logic [DSB_W-1:0]  csr_wdata
);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_READ     = 6'b000010,
      ST_SCAN     = 6'b000100,
      ST_PUT_RD   = 6'b001000,
      ST_PUT_MRG  = 6'b010000,
      ST_PUT_FULL = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [CL_W-1:0]   tail_ff, tail_in;
   logic [CN_W-1:0]   alloc_limit_ff, alloc_limit_in;
   logic [CN_W-1:0]   count_limit_ff, count_limit_in;
   logic [DSB_W-1:0]  dsb_ff, dsb_in;
   action_type        act_ff, act_in;
   logic              rd_ok_ff, rd_ok_in;
   // scan walker
   logic [ADDR_W-1:0] iaddr_ff, iaddr_in;
   logic              rvld_ff, rvld_in;
   logic [1:0]        phase_ff, phase_in;
   logic [CN_W-1:0]   pair_ff, pair_in;
   logic [7:0]        lo_ff, lo_in;
   logic [3:0]        mid_ff, mid_in;
   logic [CL_W-1:0]   cnt_ff, cnt_in;
   logic [CL_W-1:0]   found_ff, found_in;
   // entry writer
   logic [CL_W-1:0]   put_ent_ff, put_ent_in;
   logic [CL_W-1:0]   put_val_ff, put_val_in;
   logic              put_last_ff, put_last_in;
   // result
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_status_ff, rsp_status_in;
   logic [CL_W-1:0]   rsp_cluster_ff, rsp_cluster_in;
   logic [SEC_W-1:0]  rsp_sector_ff, rsp_sector_in;
   logic [CL_W-1:0]   rsp_free_ff, rsp_free_in;
   logic [7:0]        rsp_rdata_ff, rsp_rdata_in;

   mem_req_type       mem_req;
   logic [7:0]        mem_q;

   logic              accept;
   logic [CN_W-1:0]   limit_sel;
   logic [CN_W-1:0]   n_chk;
   logic [CL_W-1:0]   e_val;
   logic              in_range;
   logic              is_alloc;
   logic [CN_W:0]     first_byte;
   logic [CN_W:0]     put_base_full;
   logic [ADDR_W-1:0] put_base;
   logic              put_even;
   logic [ADDR_W-1:0] put_mrg_addr;
   logic [ADDR_W-1:0] put_full_addr;
   logic [7:0]        put_mrg_byte;
   logic [7:0]        put_full_byte;

   fca_table_ram u_table (
      .clock      (clock),
      .mem_req    (mem_req),
      .rd_data_ff (mem_q)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // Scan datapath: byte phase 1 completes the even entry of a pair, phase 2 the odd one.
   assign is_alloc   = (act_ff != ACT_COUNT);
   assign limit_sel  = is_alloc ? alloc_limit_ff : count_limit_ff;
   assign n_chk      = (phase_ff == 2'd1) ? pair_ff : pair_ff + CN_W'(1);
   assign e_val      = (phase_ff == 2'd1) ? {mem_q[3:0], lo_ff} : {mem_q, mid_ff};
   assign in_range   = (n_chk < limit_sel) && entry_exists(n_chk);
   assign first_byte = byte_of(FIRST_CLUSTER);

   // Entry writer: one byte is merged with its other nibble, the other is replaced.
   assign put_base_full = byte_of({1'b0, put_ent_ff});
   assign put_base      = put_base_full[ADDR_W-1:0];
   assign put_even      = !put_ent_ff[0];
   assign put_mrg_addr  = put_even ? put_base + ADDR_W'(1) : put_base;
   assign put_full_addr = put_even ? put_base : put_base + ADDR_W'(1);
   assign put_mrg_byte  = put_even ? {mem_q[7:4], put_val_ff[11:8]}
                                   : {put_val_ff[3:0], mem_q[3:0]};
   assign put_full_byte = put_even ? put_val_ff[7:0] : put_val_ff[11:4];

   always_comb begin
      state_in       = state_ff;
      tail_in        = tail_ff;
      alloc_limit_in = alloc_limit_ff;
      count_limit_in = count_limit_ff;
      dsb_in         = dsb_ff;
      act_in         = act_ff;
      rd_ok_in       = rd_ok_ff;
      iaddr_in       = iaddr_ff;
      rvld_in        = (state_ff == ST_SCAN);
      phase_in       = phase_ff;
      pair_in        = pair_ff;
      lo_in          = lo_ff;
      mid_in         = mid_ff;
      cnt_in         = cnt_ff;
      found_in       = found_ff;
      put_ent_in     = put_ent_ff;
      put_val_in     = put_val_ff;
      put_last_in    = put_last_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = 1'b0;
      rsp_cluster_in = '0;
      rsp_sector_in  = '0;
      rsp_free_in    = '0;
      rsp_rdata_in   = '0;
      mem_req        = '0;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ALLOC_LIMIT: alloc_limit_in = csr_wdata[CN_W-1:0];
            CSR_COUNT_LIMIT: count_limit_in = csr_wdata[CN_W-1:0];
            CSR_DATA_BASE:   dsb_in         = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  ACT_LOAD: begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = req_byte_address;
                     mem_req.wr_data = req_byte_value;
                     rsp_valid_in    = 1'b1;
                  end
                  ACT_READ: begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = req_byte_address;
                     rd_ok_in        = (req_byte_address < ADDR_W'(TABLE_BYTES));
                     state_in        = ST_READ;
                  end
                  ACT_START, ACT_APPEND, ACT_COUNT: begin
                     act_in   = action_type'(req_action);
                     iaddr_in = first_byte[ADDR_W-1:0];
                     phase_in = 2'd0;
                     pair_in  = FIRST_CLUSTER;
                     cnt_in   = '0;
                     state_in = ST_SCAN;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_rdata_in = rd_ok_ff ? mem_q : 8'h00;
            state_in     = ST_IDLE;
         end

         ST_SCAN: begin
            // stream one byte a cycle; reads issued past the end are simply dropped
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = iaddr_ff;
            iaddr_in        = iaddr_ff + ADDR_W'(1);
            if (rvld_ff) begin
               if (phase_ff == 2'd0) begin
                  lo_in    = mem_q;
                  phase_in = 2'd1;
               end else if (!in_range) begin
                  // walk ended without a hit
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = is_alloc;
                  rsp_free_in   = is_alloc ? '0 : cnt_ff;
                  state_in      = ST_IDLE;
               end else if (is_alloc && (e_val == '0)) begin
                  found_in = n_chk[CL_W-1:0];
                  if ((act_ff == ACT_APPEND) && (tail_ff != '0)
                      && entry_exists({1'b0, tail_ff})) begin
                     put_ent_in  = tail_ff;
                     put_val_in  = n_chk[CL_W-1:0];
                     put_last_in = 1'b0;
                  end else begin
                     put_ent_in  = n_chk[CL_W-1:0];
                     put_val_in  = EOC_MARK;
                     put_last_in = 1'b1;
                  end
                  state_in = ST_PUT_RD;
               end else begin
                  if (e_val == '0) begin
                     cnt_in = cnt_ff + CL_W'(1);
                  end
                  if (phase_ff == 2'd1) begin
                     mid_in   = mem_q[7:4];
                     phase_in = 2'd2;
                  end else begin
                     pair_in  = pair_ff + CN_W'(2);
                     phase_in = 2'd0;
                  end
               end
            end
         end

         ST_PUT_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = put_mrg_addr;
            state_in        = ST_PUT_MRG;
         end

         ST_PUT_MRG: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = put_mrg_addr;
            mem_req.wr_data = put_mrg_byte;
            state_in        = ST_PUT_FULL;
         end

         ST_PUT_FULL: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = put_full_addr;
            mem_req.wr_data = put_full_byte;
            if (put_last_ff) begin
               tail_in        = put_ent_ff;
               rsp_valid_in   = 1'b1;
               rsp_cluster_in = put_ent_ff;
               rsp_sector_in  = {1'b0, dsb_ff} + SEC_W'(put_ent_ff);
               state_in       = ST_IDLE;
            end else begin
               // old tail linked, now mark the new cluster end of chain
               put_ent_in  = found_ff;
               put_val_in  = EOC_MARK;
               put_last_in = 1'b1;
               state_in    = ST_PUT_RD;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         tail_ff        <= '0;
         alloc_limit_ff <= 13'd4085;
         count_limit_ff <= 13'd2880;
         dsb_ff         <= 16'd31;
         rvld_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         tail_ff        <= tail_in;
         alloc_limit_ff <= alloc_limit_in;
         count_limit_ff <= count_limit_in;
         dsb_ff         <= dsb_in;
         rvld_ff        <= rvld_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff         <= act_in;
      rd_ok_ff       <= rd_ok_in;
      iaddr_ff       <= iaddr_in;
      phase_ff       <= phase_in;
      pair_ff        <= pair_in;
      lo_ff          <= lo_in;
      mid_ff         <= mid_in;
      cnt_ff         <= cnt_in;
      found_ff       <= found_in;
      put_ent_ff     <= put_ent_in;
      put_val_ff     <= put_val_in;
      put_last_ff    <= put_last_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_cluster_ff <= rsp_cluster_in;
      rsp_sector_ff  <= rsp_sector_in;
      rsp_free_ff    <= rsp_free_in;
      rsp_rdata_ff   <= rsp_rdata_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_cluster       = rsp_cluster_ff;
   assign rsp_data_sector   = rsp_sector_ff;
   assign rsp_free_clusters = rsp_free_ff;
   assign rsp_read_data     = rsp_rdata_ff;

   // a multi-cycle transaction always ends with its result strobe
   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (state_ff == ST_IDLE) && ($past(state_ff) != ST_IDLE))
      |-> rsp_valid_ff)
      else $error("return to idle without a result strobe");

   // a failed search reports no cluster
   a_fail_no_cluster: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> ((rsp_cluster_ff == '0) && (rsp_sector_ff == '0)))
      else $error("failed allocation reports a cluster");

   // the tail moves only when the final entry write completes
   a_tail_update: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(tail_ff)) |-> ($past(state_ff) == ST_PUT_FULL))
      else $error("tail changed outside the end-of-chain write");

   // the scan walker never writes the table
   a_scan_read_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !mem_req.wr_en)
      else $error("table write during scan");

endmodule
